[rtl/gpct_pkg.sv]
// package for the grid point collision table
// holds item structs, codes, controller interface and entry layout; no dependencies
`timescale 1ns / 1ps

package gpct_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int ID_BITS       = 16;
   localparam int COORD_BITS    = 16;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS      = IDX_BITS + 1;
   localparam int KEY_BITS      = 2 * COORD_BITS;
   // entry word: used flag, key, body slot, horizontal slot, vertical slot (id, on, tag)
   localparam int ENTRY_BITS    = KEY_BITS + (ID_BITS + 1) * 3 + 2;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_UPDATE = 3'd2;
   localparam logic [2:0] OP_CHECK  = 3'd3;
   localparam logic [2:0] OP_WIRE   = 3'd4;
   localparam logic [2:0] OP_LOOP   = 3'd5;

   localparam logic [2:0] KIND_BODY  = 3'd0;
   localparam logic [2:0] KIND_ECONN = 3'd1;
   localparam logic [2:0] KIND_WCONN = 3'd2;
   localparam logic [2:0] KIND_HORIZ = 3'd3;
   localparam logic [2:0] KIND_VERT  = 3'd4;
   localparam logic [2:0] KIND_WPNT  = 3'd5;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_OCCUPIED = 3'd1;
   localparam logic [2:0] ST_MISMATCH = 3'd2;
   localparam logic [2:0] ST_TAG      = 3'd3;
   localparam logic [2:0] ST_UNKNOWN  = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] other_x;
      logic signed [15:0] other_y;
      logic [2:0]         item_kind;
      logic [15:0]        new_id;
      logic [15:0]        old_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        colliding;
      logic        wire_found;
      logic [15:0] wire_id;
   } rsp_type;

   typedef struct packed {
      logic                used;
      logic [KEY_BITS-1:0] key;
      logic                b_on;
      logic [ID_BITS-1:0]  b;
      logic                h_on;
      logic [ID_BITS-1:0]  h;
      logic                v_on;
      logic                v_tag;
      logic [ID_BITS-1:0]  v;
   } entry_type;

   // commands from controller to datapath
   typedef struct packed {
      logic init_step;   // clearing pass after reset
      logic load_req;    // capture item
      logic scan_clear;  // reset scan index and search results
      logic scan_step;   // advance scan, compare returned entry
      logic use_second;  // search for the second point
      logic save_first;  // keep first-point wire result
      logic apply;       // do the change write
      logic respond;     // drive result
   } cmd_type;

   typedef struct packed {
      logic init_done;   // every entry cleared
      logic scan_done;   // all entries compared
   } sts_type;

endpackage

[rtl/gpct_ram.sv]
// generic simple dual-port ram (one write port, one read port) with registered read
// no dependencies
`timescale 1ns / 1ps

module gpct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/gpct_datapath.sv]
// datapath: entry memory with used flags, linear scan search, slot update logic
// depends on gpct_pkg and gpct_ram
`timescale 1ns / 1ps

module gpct_datapath import gpct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);

   req_type             req_ff;
   logic [CNT_BITS-1:0] scan_ff;      // address issued, or clearing address after reset
   logic                rd_valid_ff;  // read data is for rd_idx_ff
   logic [IDX_BITS-1:0] rd_idx_ff;
   logic                hit_ff;
   logic [IDX_BITS-1:0] hit_idx_ff;
   entry_type           hit_e_ff;
   logic                free_ff;
   logic [IDX_BITS-1:0] free_idx_ff;
   logic                f0_ff;
   logic [ID_BITS-1:0]  w0_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic [KEY_BITS-1:0] key;
   entry_type           rd_e;
   logic [ENTRY_BITS-1:0] rd_data;
   logic                wr_en;
   entry_type           wr_e;
   logic [IDX_BITS-1:0] wr_idx;
   logic                ram_wr_en;
   logic [IDX_BITS-1:0] ram_wr_addr;
   logic [ENTRY_BITS-1:0] ram_wr_data;

   // key of the point being searched
   always_comb begin
      if (cmd.use_second) begin
         key = {req_ff.other_x[COORD_BITS-1:0], req_ff.other_y[COORD_BITS-1:0]};
      end else begin
         key = {req_ff.pos_x[COORD_BITS-1:0], req_ff.pos_y[COORD_BITS-1:0]};
      end
   end

   // clearing pass after reset writes every entry as unused
   always_comb begin
      if (cmd.init_step) begin
         ram_wr_en   = !scan_ff[IDX_BITS];
         ram_wr_addr = scan_ff[IDX_BITS-1:0];
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = wr_en;
         ram_wr_addr = wr_idx;
         ram_wr_data = wr_e;
      end
   end

   gpct_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (scan_ff[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );
   assign rd_e = entry_type'(rd_data);

   assign sts.scan_done = !cmd.scan_clear && !rd_valid_ff && scan_ff[IDX_BITS];
   assign sts.init_done = scan_ff[IDX_BITS];

   // scan: one entry per cycle, first match and first free slot
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req;
      end
      if (reset) begin
         scan_ff     <= '0;
         rd_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
      end else if (cmd.init_step) begin
         if (!scan_ff[IDX_BITS]) begin
            scan_ff <= scan_ff + CNT_BITS'(1);
         end
      end else if (cmd.scan_clear) begin
         scan_ff     <= '0;
         rd_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
      end else if (cmd.scan_step) begin
         rd_valid_ff <= !scan_ff[IDX_BITS];
         rd_idx_ff   <= scan_ff[IDX_BITS-1:0];
         if (!scan_ff[IDX_BITS]) begin
            scan_ff <= scan_ff + CNT_BITS'(1);
         end
         if (rd_valid_ff) begin
            if (rd_e.used && rd_e.key == key && !hit_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= rd_idx_ff;
               hit_e_ff   <= rd_e;
            end
            if (!rd_e.used && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= rd_idx_ff;
            end
         end
      end
   end

   // first wire of the matched entry
   logic               f_cur;
   logic [ID_BITS-1:0] w_cur;
   always_comb begin
      f_cur = 1'b0;
      w_cur = '0;
      if (hit_ff && hit_e_ff.h_on) begin
         f_cur = 1'b1;
         w_cur = hit_e_ff.h;
      end else if (hit_ff && hit_e_ff.v_on) begin
         f_cur = 1'b1;
         w_cur = hit_e_ff.v;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.save_first) begin
         f0_ff <= f_cur;
         w0_ff <= w_cur;
      end
   end

   // cell state classification
   logic b, h, vi, vt, vn;
   logic s_econn, s_wconn, s_whoriz, s_wvert, s_wpoint;
   logic coll;
   always_comb begin
      b  = hit_e_ff.b_on;
      h  = hit_e_ff.h_on;
      vi = hit_e_ff.v_on;
      vt = !vi && hit_e_ff.v_tag;
      vn = !vi && !vt;
      s_econn  = b && !h && vt;
      s_wconn  = !b && h && vt;
      s_whoriz = !b && h && vn;
      s_wvert  = !b && !h && vi;
      s_wpoint = !b && h && vi && hit_e_ff.h == hit_e_ff.v;
      case (req_ff.item_kind)
         KIND_BODY:  coll = 1'b1;
         KIND_ECONN: coll = !s_wconn;
         KIND_WCONN: coll = !s_econn;
         KIND_HORIZ: coll = !s_wvert;
         KIND_VERT:  coll = !s_whoriz;
         KIND_WPNT:  coll = 1'b1;
         default:    coll = !(s_econn || s_wconn || s_whoriz || s_wvert || s_wpoint);
      endcase
      coll = coll && hit_ff;
   end

   // slot change on the matched (or empty) entry
   logic [2:0] st;
   entry_type  c;
   logic [2:0] op;
   logic [ID_BITS-1:0] nid, oid;
   always_comb begin
      op  = req_ff.operation;
      nid = req_ff.new_id[ID_BITS-1:0];
      oid = req_ff.old_id[ID_BITS-1:0];
      c   = hit_ff ? hit_e_ff : '0;
      c.key = key;
      if (!c.v_on) begin
         // tag only counts when no vertical id
      end else begin
         c.v_tag = 1'b0;
      end
      st  = ST_OK;
      case (req_ff.item_kind)
         KIND_BODY, KIND_ECONN: begin
            if (req_ff.item_kind == KIND_ECONN) begin
               if (c.v_on) st = ST_TAG;
               else c.v_tag = 1'b1;
            end
            if (st == ST_OK) begin
               if (op == OP_INSERT) begin
                  if (c.b_on) st = ST_OCCUPIED;
                  else begin c.b_on = 1'b1; c.b = nid; end
               end else if (!c.b_on || c.b != oid) st = ST_MISMATCH;
               else if (op == OP_REMOVE) begin c.b_on = 1'b0; c.b = '0; end
               else c.b = nid;
            end
         end
         KIND_WCONN, KIND_HORIZ, KIND_WPNT: begin
            if (req_ff.item_kind == KIND_WCONN) begin
               if (c.v_on) st = ST_TAG;
               else c.v_tag = 1'b1;
            end
            if (st == ST_OK) begin
               if (op == OP_INSERT) begin
                  if (c.h_on) st = ST_OCCUPIED;
                  else begin c.h_on = 1'b1; c.h = nid; end
               end else if (!c.h_on || c.h != oid) st = ST_MISMATCH;
               else if (op == OP_REMOVE) begin c.h_on = 1'b0; c.h = '0; end
               else c.h = nid;
            end
            if (st == ST_OK && req_ff.item_kind == KIND_WPNT) begin
               if (op == OP_INSERT) begin
                  if (c.v_on || c.v_tag) st = ST_OCCUPIED;
                  else begin c.v_on = 1'b1; c.v = nid; end
               end else if (!c.v_on || c.v != oid) st = ST_MISMATCH;
               else if (op == OP_REMOVE) begin c.v_on = 1'b0; c.v = '0; end
               else c.v = nid;
            end
         end
         KIND_VERT: begin
            if (op == OP_INSERT) begin
               if (c.v_on || c.v_tag) st = ST_OCCUPIED;
               else begin c.v_on = 1'b1; c.v = nid; end
            end else if (!c.v_on || c.v != oid) st = ST_MISMATCH;
            else if (op == OP_REMOVE) begin c.v_on = 1'b0; c.v = '0; end
            else c.v = nid;
         end
         default: st = ST_UNKNOWN;
      endcase
      if (!c.b_on) c.b = '0;
      if (!c.h_on) c.h = '0;
      if (!c.v_on) c.v = '0;
      // entry frees itself when no slot holds an id
      c.used = c.b_on || c.h_on || c.v_on;
      if (st == ST_OK && !hit_ff && c.used && !free_ff) begin
         st = ST_FULL;
      end
   end

   // write back the changed entry, or mark a matched entry unused when it empties
   logic empty;
   assign empty  = !c.used;
   assign wr_en  = cmd.apply && st == ST_OK && (hit_ff || !empty);
   assign wr_e   = c;
   assign wr_idx = hit_ff ? hit_idx_ff : free_idx_ff;

   // result fields per operation
   always_comb begin
      rsp_in = '0;
      case (req_ff.operation)
         OP_INSERT, OP_REMOVE, OP_UPDATE: rsp_in.status = st;
         OP_CHECK: rsp_in.colliding = coll;
         OP_WIRE: begin
            rsp_in.wire_found = f_cur;
            rsp_in.wire_id    = 16'(w_cur);
         end
         OP_LOOP: begin
            rsp_in.colliding  = f0_ff && f_cur && w0_ff == w_cur;
            rsp_in.wire_found = f0_ff;
            rsp_in.wire_id    = 16'(w0_ff);
         end
         default: rsp_in = '0;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end
   assign rsp = rsp_ff;

endmodule

[rtl/gpct_ctrl.sv]
// controller state machine sequencing clearing, scans, change and result
// depends on gpct_pkg
`timescale 1ns / 1ps

module gpct_ctrl import gpct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [2:0] operation,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_SCAN1 = 7'b0000100,
      S_CLR2  = 7'b0001000,
      S_SCAN2 = 7'b0010000,
      S_DONE  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] op_ff;
   logic       valid_ff;

   always_ff @(posedge clock) begin
      if (start && !busy) op_ff <= operation;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req   = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in       = S_SCAN1;
            end
         end
         S_SCAN1: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               if (op_ff == OP_LOOP) begin
                  cmd.save_first = 1'b1;
                  state_in       = S_CLR2;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_CLR2: begin
            cmd.use_second = 1'b1;
            cmd.scan_clear = 1'b1;
            state_in       = S_SCAN2;
         end
         S_SCAN2: begin
            cmd.use_second = 1'b1;
            cmd.scan_step  = 1'b1;
            if (sts.scan_done) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.use_second = (op_ff == OP_LOOP);
            // only insert, remove and update change the table
            cmd.apply      = (op_ff == OP_INSERT) || (op_ff == OP_REMOVE) ||
                             (op_ff == OP_UPDATE);
            cmd.respond    = 1'b1;
            state_in       = S_OUT;
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= cmd.respond;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;

   // one result per item, and only right after the done state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DONE))
      else $error("result without done state");
   assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> op_ff <= OP_UPDATE)
      else $error("apply misuse");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start) |=> state_ff == S_SCAN1)
      else $error("start not taken");

endmodule

[rtl/grid_point_collision_table.sv]
// grid point collision table: one result per item, busy while searching
// each item is handled by a full scan of the 1024-entry memory at one read per cycle
// (two scans for a loop check); a new item is taken only once busy is low again; no stall
// reset: synchronous; clears control state, then a clearing pass with busy high marks
// every entry unused
`timescale 1ns / 1ps

module grid_point_collision_table import gpct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_item,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   cmd_type cmd;
   sts_type sts;

   gpct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_item.operation),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   gpct_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_item),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_item)
   );

endmodule
